[src/irtx_pkg.sv]
// Shared constants, codes and frame builder for the IR carrier serial transmitter.
package irtx_pkg;

	localparam int DATA_BITS  = 8;
	localparam int FRAME_LEN  = DATA_BITS + 2;
	localparam int POS_W      = $clog2(FRAME_LEN);
	localparam int BYTE_W     = 8;
	localparam int TICK_W     = 16;
	localparam int HALVES_W   = 7;
	localparam int HP_W       = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int ACTION_W   = 1;

	localparam logic [TICK_W-1:0]   TICKS_RST  = TICK_W'(334);
	localparam logic [HALVES_W-1:0] HALVES_RST = HALVES_W'(32);
	localparam logic [HALVES_W-1:0] HALVES_MIN = HALVES_W'(2);
	localparam logic [HALVES_W-1:0] HALVES_MAX = HALVES_W'(64);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_TICKS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HALVES_BIT  = CFG_IDX_W'(1);

	// item action codes
	localparam logic [ACTION_W-1:0] ACT_TICK = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_LOAD = 1'b1;

	// start bit 0, data LSB first (bits past the byte are 0), stop bit 1
	function automatic logic [FRAME_LEN-1:0] build_frame(input logic [BYTE_W-1:0] b);
		logic [FRAME_LEN-1:0] f;
		f = '0;
		f[FRAME_LEN-1] = 1'b1;
		for (int i = 0; i < DATA_BITS; i++) begin
			if (i < BYTE_W) begin
				f[i+1] = b[i];
			end
		end
		return f;
	endfunction

endpackage

[src/ir_carrier_uart_transmitter.sv]
// IR carrier serial transmitter: 8N1 framing, carrier burst on 0 bits.
//
// Usage:
//  - Config port: cfg_we/cfg_index/cfg_data write half_period_ticks (index 0)
//    and half_periods_per_bit (index 1) with no item in flight; the value
//    applies at once, even mid-frame. No read-back.
//  - Input channel (in_valid/in_ready): each item is a tick (action 0) or a
//    load (action 1, data_byte). A load while a frame is in flight is dropped
//    and reported as rejected.
//  - Output channel (out_valid/out_ready): exactly one result item per input
//    item: ir_level, busy_res, rejected, frame_done.
//  - Path: an accepted item sits in the input register and is processed into
//    the result register once that register is free or drains; its result is
//    offered from that point on.
//  - Throughput: one item per clock while results are taken; per item, one
//    counter increment and compare chain between the input and result registers.
//  - Stall: when out_ready is low the result holds; one more item can sit in
//    the input register, then in_ready drops until the result is taken.
//  - Reset: LED low, idle, counters cleared, registers to 334 ticks and 32
//    half-periods per bit; no items pending.
module ir_carrier_uart_transmitter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [irtx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [irtx_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [irtx_pkg::ACTION_W-1:0]    action,
	input  logic [irtx_pkg::BYTE_W-1:0]      data_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             ir_level,
	output logic                             busy_res,
	output logic                             rejected,
	output logic                             frame_done
);
	import irtx_pkg::*;

	// config registers
	logic [TICK_W-1:0]   half_ticks_q;
	logic [HALVES_W-1:0] halves_q;

	// input register
	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [BYTE_W-1:0]   byte_s1;

	// frame state
	logic                 led_q;
	logic                 sending_q;
	logic [FRAME_LEN-1:0] frame_q;
	logic [POS_W-1:0]     bitpos_q;
	logic [HP_W-1:0]      hp_q;
	logic [TICK_W-1:0]    tick_q;

	// result register
	logic out_valid_q;
	logic ir_level_q, busy_q, rejected_q, done_q;

	// next state
	logic                 led_d, sending_d, rej_d, done_d;
	logic [FRAME_LEN-1:0] frame_d;
	logic [POS_W-1:0]     bitpos_d;
	logic [HP_W-1:0]      hp_d;
	logic [TICK_W-1:0]    tick_d;

	logic [TICK_W-1:0]    eff_ticks;
	logic [HALVES_W-1:0]  eff_halves;
	logic [POS_W-1:0]     pos;
	logic [POS_W:0]       pos_inc;
	logic [TICK_W:0]      tick_inc;
	logic [HALVES_W-1:0]  hp_inc;
	logic                 advance;

	localparam logic [POS_W:0]   FRAME_LEN_C = (POS_W+1)'(FRAME_LEN);
	localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_LEN - 1);

	// handshake: stage 1 moves on whenever the result register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// effective limits: zero ticks acts as one, halves clamped to 2..64
	always_comb begin
		eff_ticks = (half_ticks_q == '0) ? TICK_W'(1) : half_ticks_q;
		if (halves_q < HALVES_MIN) begin
			eff_halves = HALVES_MIN;
		end else if (halves_q > HALVES_MAX) begin
			eff_halves = HALVES_MAX;
		end else begin
			eff_halves = halves_q;
		end
	end

	always_comb begin
		led_d     = led_q;
		sending_d = sending_q;
		frame_d   = frame_q;
		bitpos_d  = bitpos_q;
		hp_d      = hp_q;
		tick_d    = tick_q;
		rej_d     = 1'b0;
		done_d    = 1'b0;
		pos       = ({1'b0, bitpos_q} < FRAME_LEN_C) ? bitpos_q : LAST_POS;
		pos_inc   = {1'b0, pos} + (POS_W+1)'(1);
		tick_inc  = {1'b0, tick_q} + (TICK_W+1)'(1);
		hp_inc    = {1'b0, hp_q} + HALVES_W'(1);
		if (action_s1 == ACT_LOAD) begin
			if (sending_q) begin
				rej_d = 1'b1;
			end else begin
				frame_d   = build_frame(byte_s1);
				sending_d = 1'b1;
				bitpos_d  = '0;
				hp_d      = '0;
				tick_d    = '0;
			end
		end else if (sending_q) begin
			// carrier toggles at the first tick of each half-period of a 0 bit
			if (tick_q == '0 && !frame_q[pos]) begin
				led_d = !led_q;
			end
			if (tick_inc[TICK_W] || tick_inc[TICK_W-1:0] >= eff_ticks) begin
				tick_d = '0;
				if (hp_inc >= eff_halves) begin
					hp_d = '0;
					if (pos_inc >= FRAME_LEN_C) begin
						bitpos_d  = '0;
						sending_d = 1'b0;
						done_d    = 1'b1;
					end else begin
						bitpos_d = pos_inc[POS_W-1:0];
					end
				end else begin
					hp_d = hp_inc[HP_W-1:0];
				end
			end else begin
				tick_d = tick_inc[TICK_W-1:0];
			end
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ticks_q <= TICKS_RST;
			halves_q     <= HALVES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HALF_TICKS: half_ticks_q <= cfg_data[TICK_W-1:0];
				REG_HALVES_BIT: halves_q     <= cfg_data[HALVES_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			byte_s1   <= data_byte;
		end
	end

	// frame state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q       <= 1'b0;
			sending_q   <= 1'b0;
			frame_q     <= '1;
			bitpos_q    <= '0;
			hp_q        <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				led_q     <= led_d;
				sending_q <= sending_d;
				frame_q   <= frame_d;
				bitpos_q  <= bitpos_d;
				hp_q      <= hp_d;
				tick_q    <= tick_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			ir_level_q <= led_d;
			busy_q     <= sending_d;
			rejected_q <= rej_d;
			done_q     <= done_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign ir_level   = ir_level_q;
	assign busy_res   = busy_q;
	assign rejected   = rejected_q;
	assign frame_done = done_q;

	// a dropped load leaves the frame running
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rejected_q |-> busy_q)
		else $error("rejected item without busy");

	// frame end clears busy and never coincides with a reject
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> !busy_q && !rejected_q)
		else $error("frame_done with busy or rejected");

	// counters are parked at zero while idle
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> tick_q == '0 && hp_q == '0 && bitpos_q == '0)
		else $error("counters not cleared while idle");

	// an item held in stage 1 during a stall stays valid and unchanged
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(action_s1) && $stable(byte_s1))
		else $error("stage 1 item lost during stall");

endmodule
